// ===== design/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Types, constants and Q4.12 arithmetic helpers for the escape-time core.
// ----------------------------------------------------------------------------
package mbe_pkg;

	localparam int unsigned W = 16;
	localparam int unsigned CW = 6;

	localparam logic [2:0] BAND_LT4 = 3'd0;
	localparam logic [2:0] BAND_LT8 = 3'd1;
	localparam logic [2:0] BAND_LT16 = 3'd2;
	localparam logic [2:0] BAND_LTLIM = 3'd3;
	localparam logic [2:0] BAND_BLACK = 3'd4;

	typedef struct packed {
		logic          valid;
		logic          done;
		logic          esc;
		logic [W-1:0]  zr;
		logic [W-1:0]  zi;
		logic [W-1:0]  cr;
		logic [W-1:0]  ci;
		logic [CW-1:0] cnt;
		logic [CW-1:0] lim;
	} mbe_stage_t;

	function automatic logic [W-1:0] qmul(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W-1:0]   ma;
		logic [W-1:0]   mb;
		logic [2*W-2:0] p;
		logic [W-1:0]   r;
		ma = a[W-1] ? (~a + 16'd1) : a;
		mb = b[W-1] ? (~b + 16'd1) : b;
		p = ma * mb[W-2:0];
		r = p[W+11:12];
		return (a[W-1] ^ b[W-1]) ? (~r + 16'd1) : r;
	endfunction

	function automatic logic big(input logic [W-1:0] v);
		return !v[15] && (v[14] || v[13]);
	endfunction

endpackage

// ===== design/mbe_if.sv =====
// ----------------------------------------------------------------------------
// mbe interfaces
// Valid/ready channels for points, results and the limit register.
// ----------------------------------------------------------------------------
interface mbe_pixel_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] c_real;
	logic signed [15:0] c_imag;
	modport source (output valid, c_real, c_imag, input ready);
	modport sink (input valid, c_real, c_imag, output ready);
endinterface

interface mbe_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] color_band;
	logic [5:0] iteration_count;
	logic       escaped;
	modport source (output valid, color_band, iteration_count, escaped, input ready);
	modport sink (input valid, color_band, iteration_count, escaped, output ready);
endinterface

interface mbe_cfg_if;
	logic       valid;
	logic       ready;
	logic [5:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== design/mbe_cell.sv =====
// ----------------------------------------------------------------------------
// mbe_cell
// One iteration z = z*z + c; passes finished points through unchanged.
// ----------------------------------------------------------------------------
module mbe_cell import mbe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  mbe_stage_t prev,
	output mbe_stage_t cur
);

	mbe_stage_t   nxt;
	mbe_stage_t   stage_q;
	logic [W-1:0] rs;
	logic [W-1:0] is2;
	logic [W-1:0] nr;
	logic [W-1:0] ni;
	logic [CW-1:0] cnt1;
	logic         esc;

	always_comb begin
		rs = qmul(prev.zr, prev.zr);
		is2 = qmul(prev.zi, prev.zi);
		ni = qmul({prev.zi[W-2:0], 1'b0}, prev.zr) + prev.ci;
		nr = rs - is2 + prev.cr;
		cnt1 = prev.cnt + 6'd1;
		esc = big(nr) || big(~nr + 16'd1) || big(ni) || big(~ni + 16'd1);
		nxt = prev;
		if (!prev.done) begin
			nxt.zr = nr;
			nxt.zi = ni;
			nxt.cnt = cnt1;
			nxt.esc = esc;
			nxt.done = esc || (cnt1 >= prev.lim);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
		end else if (adv) begin
			stage_q <= nxt;
		end
	end

	assign cur = stage_q;

endmodule

// ===== design/mandelbrot_escape_time_q4_12_core.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_q4_12_core
// Escape-time count and color band for Q4.12 points, one cell per iteration.
// ----------------------------------------------------------------------------
// channel | dir | payload
// pixel   | in  | c_real, c_imag
// result  | out | color_band, iteration_count, escaped
// cfg     | in  | data (max_iterations)
//
// A point passes through every cell register of the row, then the output register.
// A new point enters each cycle while the result is not stalled; cells hold finished points until the end.
// Reset clears the row and sets the limit to min(MAX_ITER,63).
// A stalled result freezes the whole row and drops pixel.ready.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_q4_12_core import mbe_pkg::*; #(
	parameter int unsigned MAX_ITER = 32
) (
	input  logic clk,
	input  logic arst_n,
	mbe_pixel_if.sink    pixel,
	mbe_result_if.source result,
	mbe_cfg_if.sink      cfg
);

	localparam int unsigned NCELL = (MAX_ITER > 63) ? 63 : MAX_ITER;

	mbe_stage_t    stage [0:NCELL];
	logic          adv;
	logic [CW-1:0] lim_q;
	logic [CW-1:0] lim_eff;
	logic          out_valid_q;
	logic [2:0]    band_q;
	logic [CW-1:0] cnt_q;
	logic          esc_q;
	logic [2:0]    band;
	mbe_stage_t    last;

	assign adv = !out_valid_q || result.ready;
	assign pixel.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= CW'(NCELL);
		end else if (cfg.valid) begin
			lim_q <= cfg.data;
		end
	end

	always_comb begin
		if (lim_q == '0) begin
			lim_eff = CW'(1);
		end else if (lim_q > CW'(NCELL)) begin
			lim_eff = CW'(NCELL);
		end else begin
			lim_eff = lim_q;
		end
		stage[0] = '0;
		stage[0].valid = pixel.valid;
		stage[0].cr = pixel.c_real;
		stage[0].ci = pixel.c_imag;
		stage[0].lim = lim_eff;
	end

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		mbe_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.prev   (stage[i]),
			.cur    (stage[i+1])
		);
	end

	assign last = stage[NCELL];

	always_comb begin
		if (last.cnt >= last.lim) begin
			band = BAND_BLACK;
		end else if (last.cnt < 6'd4) begin
			band = BAND_LT4;
		end else if (last.cnt < 6'd8) begin
			band = BAND_LT8;
		end else if (last.cnt < 6'd16) begin
			band = BAND_LT16;
		end else begin
			band = BAND_LTLIM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			band_q <= '0;
			cnt_q <= '0;
			esc_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= last.valid;
			band_q <= band;
			cnt_q <= last.cnt;
			esc_q <= last.esc;
		end
	end

	assign result.valid = out_valid_q;
	assign result.color_band = band_q;
	assign result.iteration_count = cnt_q;
	assign result.escaped = esc_q;

	a_black_if_no_escape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !esc_q |-> band_q == BAND_BLACK)
		else $error("result without escape must be black");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> cnt_q != '0)
		else $error("result with zero iterations");

	a_band_needs_escape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && band_q != BAND_BLACK |-> esc_q)
		else $error("colored band without escape");

endmodule

// ===== test/tb_mandelbrot_escape_time_q4_12_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time_q4_12_core
// Drives Q4.12 points through the escape-time core at several iteration
// limits, predicts count, band and escape flag, and checks each result.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time_q4_12_core;
	import mbe_pkg::*;

	localparam int unsigned MAX_ITER = 32;
	localparam int unsigned LATENCY = MAX_ITER + 1;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct packed {
		logic [15:0] c_real;
		logic [15:0] c_imag;
	} point_t;

	typedef struct packed {
		logic [2:0] color_band;
		logic [5:0] iteration_count;
		logic       escaped;
	} escape_t;

	logic clk;
	logic arst_n;

	mbe_pixel_if  pixel();
	mbe_result_if result();
	mbe_cfg_if    cfg();

	mandelbrot_escape_time_q4_12_core #(.MAX_ITER(MAX_ITER)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel),
		.result (result),
		.cfg    (cfg)
	);

	point_t      pending_points[$];
	escape_t     expected_escapes[$];
	logic  [5:0] iter_limit;
	logic        quiet;
	int          send_gap;
	int          stall_gap;
	int          cycle_count;
	int          mismatches;
	int          points_sent;
	int          results_seen;
	int          escapes_seen;
	int          blacks_seen;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [15:0] neg16(input logic [15:0] v);
		return ~v + 16'd1;
	endfunction

	function automatic logic [15:0] fixed_mul(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] ma;
		logic [15:0] mb;
		logic [31:0] prod;
		logic [15:0] r;
		ma = a[15] ? neg16(a) : a;
		mb = b[15] ? neg16(b) : b;
		prod = {16'd0, ma} * {17'd0, mb[14:0]};
		r = prod[27:12];
		return (a[15] ^ b[15]) ? neg16(r) : r;
	endfunction

	function automatic logic outside_two(input logic [15:0] v);
		return !v[15] && (v[14] || v[13]);
	endfunction

	function automatic escape_t escape_time(input point_t p, input logic [5:0] reg_lim);
		int          lim;
		int          count;
		logic        esc;
		logic [15:0] zr;
		logic [15:0] zi;
		logic [15:0] nr;
		logic [15:0] ni;
		escape_t     res;
		lim = (reg_lim == 0) ? 1 : int'(reg_lim);
		if (lim > MAX_ITER)
			lim = MAX_ITER;
		zr = '0;
		zi = '0;
		count = 0;
		do begin
			nr = fixed_mul(zr, zr) - fixed_mul(zi, zi) + p.c_real;
			ni = fixed_mul(zi << 1, zr) + p.c_imag;
			zr = nr;
			zi = ni;
			count++;
			esc = outside_two(zi) || outside_two(neg16(zi)) ||
				outside_two(zr) || outside_two(neg16(zr));
		end while (!esc && count < lim);
		if (count >= lim)
			res.color_band = BAND_BLACK;
		else if (count < 4)
			res.color_band = BAND_LT4;
		else if (count < 8)
			res.color_band = BAND_LT8;
		else if (count < 16)
			res.color_band = BAND_LT16;
		else
			res.color_band = BAND_LTLIM;
		res.iteration_count = count[5:0];
		res.escaped = esc;
		return res;
	endfunction

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
			results_seen);
		mismatches++;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel.valid <= 1'b0;
			pixel.c_real <= '0;
			pixel.c_imag <= '0;
			send_gap <= 0;
		end else begin
			if (pixel.valid && pixel.ready) begin
				expected_escapes.push_back(escape_time({pixel.c_real, pixel.c_imag}, iter_limit));
				points_sent <= points_sent + 1;
			end
			if (!pixel.valid || pixel.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					pixel.valid <= 1'b0;
				end else if (pending_points.size() > 0) begin
					point_t p;
					p = pending_points.pop_front();
					pixel.valid <= 1'b1;
					pixel.c_real <= p.c_real;
					pixel.c_imag <= p.c_imag;
					if (!quiet && $urandom_range(0, 5) == 0)
						send_gap <= $urandom_range(1, 4);
				end else begin
					pixel.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			stall_gap <= 0;
		end else begin
			if (result.valid && result.ready) begin
				escape_t want;
				if (expected_escapes.size() == 0) begin
					report("unexpected result", 16'(result.iteration_count), 16'd0);
				end else begin
					want = expected_escapes.pop_front();
					if (result.color_band !== want.color_band)
						report("color_band", 16'(result.color_band), 16'(want.color_band));
					if (result.iteration_count !== want.iteration_count)
						report("iteration_count", 16'(result.iteration_count),
							16'(want.iteration_count));
					if (result.escaped !== want.escaped)
						report("escaped", 16'(result.escaped), 16'(want.escaped));
				end
				results_seen <= results_seen + 1;
				if (result.escaped)
					escapes_seen <= escapes_seen + 1;
				if (result.color_band == BAND_BLACK)
					blacks_seen <= blacks_seen + 1;
			end
			if (stall_gap > 0) begin
				stall_gap <= stall_gap - 1;
				result.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				stall_gap <= $urandom_range(0, 3);
				result.ready <= 1'b0;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	task automatic wait_drained();
		while (pending_points.size() > 0 || pixel.valid || expected_escapes.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [5:0] value);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		iter_limit = value;
	endtask

	function automatic logic [15:0] rand_component();
		case ($urandom_range(0, 4))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'($signed($urandom_range(0, 12288)) - 8192);
			2: return 16'($signed($urandom_range(0, 2048)) - 1024);
			3: return {$urandom_range(0, 1) ? 4'hf : 4'h0, 12'($urandom_range(0, 4095))};
			default: return 16'($urandom_range(0, 1) ? 16'h8000 : 16'h7fff);
		endcase
	endfunction

	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++)
			pending_points.push_back({rand_component(), rand_component()});
	endtask

	initial begin
		logic [5:0] limits[6];
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		pixel.valid = 1'b0;
		pixel.c_real = '0;
		pixel.c_imag = '0;
		result.ready = 1'b0;
		quiet = 1'b0;
		cycle_count = 0;
		mismatches = 0;
		points_sent = 0;
		results_seen = 0;
		escapes_seen = 0;
		blacks_seen = 0;
		iter_limit = 6'(MAX_ITER);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset limit, extremes, minus eight, in-set points, wrapping
		pending_points.push_back({16'h0000, 16'h0000});
		pending_points.push_back({16'h7fff, 16'h7fff});
		pending_points.push_back({16'h8000, 16'h8000});
		pending_points.push_back({16'h8000, 16'h0000});
		pending_points.push_back({16'h0000, 16'h8000});
		pending_points.push_back({16'h7fff, 16'h8000});
		pending_points.push_back({16'hffff, 16'h0001});
		pending_points.push_back({16'he000, 16'h0000});
		pending_points.push_back({16'h2000, 16'h0000});
		pending_points.push_back({16'h1fff, 16'h0000});
		pending_points.push_back({16'hc000, 16'h0000});
		pending_points.push_back({16'h0000, 16'h1000});
		pending_points.push_back({16'hf000, 16'h0000});
		pending_points.push_back({16'h0400, 16'h0a00});
		pending_points.push_back({16'h0600, 16'h0000});
		pending_points.push_back({16'hfc00, 16'h0b00});
		pending_points.push_back({16'h5555, 16'haaaa});
		pending_points.push_back({16'haaaa, 16'h5555});
		wait_drained();

		limits = '{6'd0, 6'd1, 6'd63, 6'd4, 6'd17, 6'd32};
		foreach (limits[k]) begin
			write_limit(limits[k]);
			queue_random(180);
			// in each phase, wait until at most half of the queued points remain, then drain
			while (pending_points.size() > 90)
				@(posedge clk);
			wait_drained();
		end
		write_limit(6'($urandom_range(2, 31)));
		queue_random(60);
		wait_drained();
		quiet = 1'b1;
		queue_random(60);
		wait_drained();

		$display("Covered %0d points over limits 0, 1, 4, 17, 32, 63 and one random limit;",
			points_sent);
		$display("%0d results, %0d escaped, %0d black.", results_seen, escapes_seen,
			blacks_seen);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== mandelbrot_escape_time_q4_12_core.f =====
design/mbe_pkg.sv
design/mbe_if.sv
design/mbe_cell.sv
design/mandelbrot_escape_time_q4_12_core.sv
test/tb_mandelbrot_escape_time_q4_12_core.sv
